// File: src/text_console_char_writer_macros.svh
// assertion macros shared by the console writer modules
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw assertion failed");

`endif

// File: src/tcw_pkg.sv
// shared constants and types of the text console character writer
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int SCREEN_WIDTH_DEF  = 80;
    localparam int SCREEN_HEIGHT_DEF = 25;

    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int INDEX_W  = 11;
    localparam int DATA_W   = 16;
    localparam int CUR_COL_W = 7;
    localparam int CUR_ROW_W = 5;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    localparam int TAB_STOP = 4;
    localparam int TAB_W    = $clog2(TAB_STOP);

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE
    } cur_op_t;

    typedef struct packed {
        logic    step;
        cur_op_t op;
    } cur_cmd_t;

    typedef struct packed {
        logic             scroll;
        logic [TAB_W-1:0] tab_rem;
    } cur_stat_t;

endpackage

// File: src/tcw_cursor.sv
// cursor unit: column, row and line base, stepped once per result
`timescale 1ns / 1ps
`include "text_console_char_writer_macros.svh"

module tcw_cursor #(
    parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcw_pkg::cur_cmd_t                cmd,
    output logic [tcw_pkg::INDEX_W-1:0]      cell_index,
    output logic [tcw_pkg::CUR_COL_W-1:0]    column_next,
    output logic [tcw_pkg::CUR_ROW_W-1:0]    row_next,
    output tcw_pkg::cur_stat_t               stat
);
    import tcw_pkg::*;

    localparam int ColW  = $clog2(SCREEN_WIDTH);
    localparam int RowW  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int BaseW = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);

    logic [ColW-1:0]  col_reg,  col_next;
    logic [RowW-1:0]  row_reg,  row_nxt;
    logic [BaseW-1:0] base_reg, base_next;

    logic [ColW:0]    col_inc;
    logic             wrap;
    logic             row_step;
    logic             at_bottom;
    logic [BaseW-1:0] idx_full;
    logic [BaseW+INDEX_W-1:0]   idx_wide;
    logic [ColW+CUR_COL_W-1:0]  col_wide;
    logic [RowW+CUR_ROW_W-1:0]  row_wide;

    always_comb
    begin
        col_inc   = {1'b0, col_reg} + (ColW+1)'(1);
        wrap      = (col_inc == (ColW+1)'(SCREEN_WIDTH));
        row_step  = (cmd.op == CUR_NEWLINE) || ((cmd.op == CUR_ADVANCE) && wrap);
        at_bottom = (row_reg == RowW'(SCREEN_HEIGHT - 1));

        unique case (cmd.op)
            CUR_NEWLINE: col_next = '0;
            CUR_ADVANCE: col_next = wrap ? '0 : col_inc[ColW-1:0];
            default:     col_next = col_reg;
        endcase

        // past the last row the row holds and the display scrolls instead
        if (row_step && !at_bottom)
        begin
            row_nxt   = RowW'(row_reg + RowW'(1));
            base_next = BaseW'(base_reg + BaseW'(SCREEN_WIDTH));
        end
        else
        begin
            row_nxt   = row_reg;
            base_next = base_reg;
        end

        stat.scroll  = row_step && at_bottom;
        stat.tab_rem = ~col_reg[TAB_W-1:0];

        idx_full = BaseW'(base_reg + BaseW'(col_reg));
        idx_wide = (BaseW+INDEX_W)'(idx_full);
        col_wide = (ColW+CUR_COL_W)'(col_next);
        row_wide = (RowW+CUR_ROW_W)'(row_nxt);
    end

    assign cell_index  = idx_wide[INDEX_W-1:0];
    assign column_next = col_wide[CUR_COL_W-1:0];
    assign row_next    = row_wide[CUR_ROW_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else if (cmd.step)
        begin
            col_reg  <= col_next;
            row_reg  <= row_nxt;
            base_reg <= base_next;
        end
    end

    `TCW_ASSERT_NOW(a_col_in_range, 1'b1, {1'b0, col_reg} < (ColW+1)'(SCREEN_WIDTH))
    `TCW_ASSERT_NOW(a_row_in_range, 1'b1, row_reg <= RowW'(SCREEN_HEIGHT - 1))
    `TCW_ASSERT_NEXT(a_scroll_holds_bottom, cmd.step && stat.scroll, row_reg == RowW'(SCREEN_HEIGHT - 1))

endmodule

// File: src/text_console_char_writer.sv
// text console character writer: request sequencer and result register
`timescale 1ns / 1ps
`include "text_console_char_writer_macros.svh"

// Takes one character request (byte, attribute, in-place flag) and produces its cell writes
// on the result channel, one result per cycle while out_stall does not hold the output
// register, as a cursor unit tracks column and row on a SCREEN_WIDTH x SCREEN_HEIGHT screen.
// A newline or an ordinary character gives one result; a tab gives n spaces (1 to 4), n
// set by the column at accept, and the cursor steps once per result. in_stall stays high
// from accept until the last result of the request is loaded into the output register, so
// the next request can enter while that result still waits to be taken. Newline results
// carry no cell write; scroll_request flags that the display memory must scroll one row.
module text_console_char_writer #(
    parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic                            in_place,
    input  logic [tcw_pkg::COLOR_W-1:0]     color,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            cell_write,
    output logic [tcw_pkg::INDEX_W-1:0]     cell_index,
    output logic [tcw_pkg::DATA_W-1:0]      cell_data,
    output logic                            scroll_request,
    output logic [tcw_pkg::CUR_COL_W-1:0]   cursor_column,
    output logic [tcw_pkg::CUR_ROW_W-1:0]   cursor_row,
    output logic                            last
);
    import tcw_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_TAB,
        KIND_NEWLINE
    } kind_t;

    state_t                 state_reg, state_next;
    kind_t                  kind_reg, kind_next;
    logic [TAB_W-1:0]       rem_reg, rem_next;
    logic [CHAR_W-1:0]      char_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic                   in_place_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   cell_write_reg, cell_write_next;
    logic [INDEX_W-1:0]     cell_index_reg, cell_index_next;
    logic [DATA_W-1:0]      cell_data_reg, cell_data_next;
    logic                   scroll_reg, scroll_next;
    logic [CUR_COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [CUR_ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic                   last_reg, last_next;

    logic                   accept;
    logic                   emit;
    logic                   last_now;

    cur_cmd_t               cmd;
    cur_stat_t              stat;
    logic [INDEX_W-1:0]     cur_index;
    logic [CUR_COL_W-1:0]   col_after;
    logic [CUR_ROW_W-1:0]   row_after;

    tcw_cursor #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cursor (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cell_index  (cur_index),
        .column_next (col_after),
        .row_next    (row_after),
        .stat        (stat)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    // a result goes out when the output register is empty or being drained
    assign emit     = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign last_now = (kind_reg != KIND_TAB) || (rem_reg == '0);

    always_comb
    begin
        cmd.step = emit;
        unique case (kind_reg)
            KIND_NEWLINE: cmd.op = CUR_NEWLINE;
            KIND_TAB:     cmd.op = CUR_ADVANCE;
            default:      cmd.op = in_place_reg ? CUR_HOLD : CUR_ADVANCE;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cell_write_next = cell_write_reg;
        cell_index_next = cell_index_reg;
        cell_data_next  = cell_data_reg;
        scroll_next     = scroll_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        last_next       = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EMIT;
                    // tab space count is fixed by the column at accept time
                    rem_next   = stat.tab_rem;
                    if (char_code == CH_NEWLINE)
                        kind_next = KIND_NEWLINE;
                    else if (char_code == CH_TAB)
                        kind_next = KIND_TAB;
                    else
                        kind_next = KIND_CHAR;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    scroll_next    = stat.scroll;
                    cur_col_next   = col_after;
                    cur_row_next   = row_after;
                    last_next      = last_now;
                    rem_next       = TAB_W'(rem_reg - TAB_W'(1));
                    unique case (kind_reg)
                        KIND_NEWLINE:
                        begin
                            cell_write_next = 1'b0;
                            cell_index_next = '0;
                            cell_data_next  = '0;
                        end
                        KIND_TAB:
                        begin
                            cell_write_next = 1'b1;
                            cell_index_next = cur_index;
                            cell_data_next  = {color_reg, CH_SPACE};
                        end
                        default:
                        begin
                            cell_write_next = 1'b1;
                            cell_index_next = cur_index;
                            cell_data_next  = {color_reg, char_reg};
                        end
                    endcase
                    if (last_now)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kind_reg       <= KIND_CHAR;
            rem_reg        <= '0;
            out_valid_reg  <= 1'b0;
            cell_write_reg <= 1'b0;
            cell_index_reg <= '0;
            cell_data_reg  <= '0;
            scroll_reg     <= 1'b0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            last_reg       <= 1'b0;
            char_reg       <= '0;
            color_reg      <= '0;
            in_place_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            rem_reg        <= rem_next;
            out_valid_reg  <= out_valid_next;
            cell_write_reg <= cell_write_next;
            cell_index_reg <= cell_index_next;
            cell_data_reg  <= cell_data_next;
            scroll_reg     <= scroll_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            last_reg       <= last_next;
            if (accept)
            begin
                char_reg     <= char_code;
                color_reg    <= color;
                in_place_reg <= in_place;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_write     = cell_write_reg;
    assign cell_index     = cell_index_reg;
    assign cell_data      = cell_data_reg;
    assign scroll_request = scroll_reg;
    assign cursor_column  = cur_col_reg;
    assign cursor_row     = cur_row_reg;
    assign last           = last_reg;

    `TCW_ASSERT_NEXT(a_accept_goes_busy, accept, in_stall)
    `TCW_ASSERT_NOW(a_newline_no_cell, out_valid_reg && !cell_write_reg, (cell_index_reg == '0) && (cell_data_reg == '0) && last_reg)
    `TCW_ASSERT_NOW(a_only_tab_continues, out_valid_reg && !last_reg, (state_reg == ST_EMIT) && (kind_reg == KIND_TAB))

endmodule
